### sv/ddwc_pkg.sv
// shared constants, types and helpers of the wheel command unit
`default_nettype none
package ddwc_pkg;
   localparam int SPEED_WIDTH_DEF = 16;
   localparam int RPM_W           = 16;
   localparam int DUTY_W          = 17;
   localparam int CIRC_W          = 20;
   localparam int TRACK_W         = 12;
   localparam int MAXRPM_W        = 14;
   localparam int BITS_W          = 5;
   localparam int FULL_W          = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 20;
   localparam int QUOT_W          = 17;

   localparam logic [CIRC_W:0]     CIRC2_RESET  = 21'd628318;
   localparam logic [TRACK_W-1:0]  TRACK_RESET  = 12'd300;
   localparam logic [MAXRPM_W-1:0] MAXRPM_RESET = 14'd140;
   localparam logic [FULL_W-1:0]   FULL_RESET   = 16'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIRC   = 3'd0,
      CSR_TRACK  = 3'd1,
      CSR_MAXRPM = 3'd2,
      CSR_BITS   = 3'd3
   } csr_index_type;

   // full scale pwm value, resolution capped at sixteen bits
   function automatic logic [FULL_W-1:0] full_scale(input logic [BITS_W-1:0] bits);
      logic [BITS_W-1:0] b;
      logic [FULL_W:0]   f;
      begin
         b = (bits > BITS_W'(16)) ? BITS_W'(16) : bits;
         f = (17'd1 << b) - 17'd1;
         full_scale = f[FULL_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

### sv/ddwc_if.sv
// request and response channel interfaces
`default_nettype none
interface ddwc_req_if #(parameter int SPEED_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] linear_speed;
   logic signed [SPEED_WIDTH-1:0] yaw_rate;
   modport source (output valid, linear_speed, yaw_rate, input ready);
   modport sink   (input valid, linear_speed, yaw_rate, output ready);
endinterface

interface ddwc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_rpm;
   logic signed [15:0] right_rpm;
   logic signed [16:0] left_duty;
   logic signed [16:0] right_duty;
   logic               clipped;
   modport source (output valid, left_rpm, right_rpm, left_duty, right_duty, clipped,
                   input ready);
   modport sink   (input valid, left_rpm, right_rpm, left_duty, right_duty, clipped,
                   output ready);
endinterface
`default_nettype wire

### sv/ddwc_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module ddwc_div #(
   parameter int DVD_W = 36,
   parameter int DVS_W = 21,
   parameter int Q_W   = 17,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [Q_W-1:0]        quotient,
   output logic                  ovf,
   output logic [TAG_W-1:0]      out_tag
);
   localparam int HI_W  = DVD_W - Q_W;
   localparam int CMP_W = (HI_W > DVS_W) ? HI_W : DVS_W;

   logic [DVS_W-1:0] rem_ff   [Q_W+1];
   logic [Q_W-1:0]   low_ff   [Q_W+1];
   logic [Q_W-1:0]   q_ff     [Q_W+1];
   logic             ovf_ff   [Q_W+1];
   logic [TAG_W-1:0] tag_ff   [Q_W+1];
   logic             valid_ff [Q_W+1];

   logic [HI_W-1:0]  hi_in;
   logic             ovf_in;

   assign hi_in  = dividend[DVD_W-1:Q_W];
   assign ovf_in = CMP_W'(hi_in) >= CMP_W'(divisor);

   // entry stage: the high part is the starting remainder when no overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= DVS_W'(hi_in);
         low_ff[0] <= dividend[Q_W-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= ovf_in;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DVS_W:0]   trial_in;
      logic             ge_in;
      logic [DVS_W:0]   diff_in;
      logic [DVS_W-1:0] rem_in;

      assign trial_in = {rem_ff[k], low_ff[k][Q_W-1]};
      assign ge_in    = trial_in >= {1'b0, divisor};
      assign diff_in  = trial_in - {1'b0, divisor};
      assign rem_in   = ge_in ? diff_in[DVS_W-1:0] : trial_in[DVS_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= {low_ff[k][Q_W-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][Q_W-2:0], ge_in};
            ovf_ff[k+1] <= ovf_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign quotient  = q_ff[Q_W];
   assign ovf       = ovf_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];
endmodule
`default_nettype wire

### sv/ddwc_front.sv
// body command to wheel surface speed dividends, three stages
`default_nettype none
module ddwc_front #(
   parameter int SW = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic signed [SW-1:0]      linear_speed,
   input  wire logic signed [SW-1:0]      yaw_rate,
   input  wire logic [ddwc_pkg::TRACK_W-1:0] track,
   output logic                           out_valid,
   output logic [SW+19:0]                 dvd_l,
   output logic [SW+19:0]                 dvd_r,
   output logic                           neg_l,
   output logic                           neg_r
);
   import ddwc_pkg::*;

   logic signed [SW+10:0] lin_in, lin_ff;
   logic signed [SW+12:0] tan_in, tan_ff;
   logic signed [SW+13:0] sum_l_in, sum_l_ff, sum_r_in, sum_r_ff;
   logic [SW+13:0]        mag_l_in, mag_r_in;
   logic [SW+19:0]        dvd_l_in, dvd_l_ff, dvd_r_in, dvd_r_ff;
   logic                  neg_l_ff, neg_r_ff;
   logic [2:0]            valid_ff;

   assign lin_in   = linear_speed * $signed(12'd2000);
   assign tan_in   = yaw_rate * $signed({1'b0, track});
   assign sum_l_in = lin_ff - tan_ff;
   assign sum_r_in = lin_ff + tan_ff;
   assign mag_l_in = sum_l_ff[SW+13] ? (SW+14)'(-sum_l_ff) : (SW+14)'(sum_l_ff);
   assign mag_r_in = sum_r_ff[SW+13] ? (SW+14)'(-sum_r_ff) : (SW+14)'(sum_r_ff);
   // times 60 as 64x - 4x
   assign dvd_l_in = {mag_l_in, 6'b0} - {4'b0, mag_l_in, 2'b0};
   assign dvd_r_in = {mag_r_in, 6'b0} - {4'b0, mag_r_in, 2'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      if (en) begin
         lin_ff   <= lin_in;
         tan_ff   <= tan_in;
         sum_l_ff <= sum_l_in;
         sum_r_ff <= sum_r_in;
         dvd_l_ff <= dvd_l_in;
         dvd_r_ff <= dvd_r_in;
         neg_l_ff <= sum_l_ff[SW+13];
         neg_r_ff <= sum_r_ff[SW+13];
      end
   end

   assign out_valid = valid_ff[2];
   assign dvd_l     = dvd_l_ff;
   assign dvd_r     = dvd_r_ff;
   assign neg_l     = neg_l_ff;
   assign neg_r     = neg_r_ff;
endmodule
`default_nettype wire

### sv/ddwc_wheel.sv
// one wheel: rpm divide, saturate, duty scale and divide, clamp
`default_nettype none
module ddwc_wheel #(
   parameter int SW = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic [SW+19:0]                 dvd,
   input  wire logic                           neg,
   input  wire logic [ddwc_pkg::CIRC_W:0]      circ2,
   input  wire logic [ddwc_pkg::MAXRPM_W-1:0]  maxrpm,
   input  wire logic [ddwc_pkg::FULL_W-1:0]    full,
   output logic                                out_valid,
   output logic signed [ddwc_pkg::RPM_W-1:0]   rpm,
   output logic signed [ddwc_pkg::DUTY_W-1:0]  duty,
   output logic                                clip
);
   import ddwc_pkg::*;

   localparam int TAG2_W = RPM_W + 2;

   logic              v1, ovf1, neg1;
   logic [QUOT_W-1:0] q1;

   ddwc_div #(.DVD_W(SW + 20), .DVS_W(CIRC_W + 1), .Q_W(QUOT_W), .TAG_W(1)) u_rpm_div (
      .clock, .reset, .en,
      .in_valid (in_valid), .dividend (dvd), .divisor (circ2), .in_tag (neg),
      .out_valid (v1), .quotient (q1), .ovf (ovf1), .out_tag (neg1)
   );

   // saturation to the rpm field
   logic                    big_in;
   logic signed [RPM_W-1:0] rpm_in, rpm_ff;
   logic [RPM_W-1:0]        mag_in, mag_ff;
   logic                    neg_ff, clip_ff, sat_valid_ff;

   always_comb begin
      if (neg1) begin
         big_in = ovf1 || (q1 > 17'd32768);
         mag_in = big_in ? 16'd32768 : q1[RPM_W-1:0];
      end else begin
         big_in = ovf1 || (q1 > 17'd32767);
         mag_in = big_in ? 16'd32767 : q1[RPM_W-1:0];
      end
      rpm_in = neg1 ? -$signed(mag_in) : $signed(mag_in);
   end

   // duty numerator
   logic [2*FULL_W-1:0]     prod_in, prod_ff;
   logic signed [RPM_W-1:0] rpm_m_ff;
   logic                    neg_m_ff, clip_m_ff, mul_valid_ff;

   assign prod_in = mag_ff * full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         sat_valid_ff <= v1;
         mul_valid_ff <= sat_valid_ff;
      end
      if (en) begin
         rpm_ff    <= rpm_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg1;
         clip_ff   <= big_in;
         prod_ff   <= prod_in;
         rpm_m_ff  <= rpm_ff;
         neg_m_ff  <= neg_ff;
         clip_m_ff <= clip_ff;
      end
   end

   logic              v2, ovf2;
   logic [QUOT_W-1:0] q2;
   logic [TAG2_W-1:0] tag2;

   ddwc_div #(.DVD_W(2 * FULL_W), .DVS_W(MAXRPM_W), .Q_W(QUOT_W), .TAG_W(TAG2_W)) u_duty_div (
      .clock, .reset, .en,
      .in_valid (mul_valid_ff), .dividend (prod_ff), .divisor (maxrpm),
      .in_tag ({neg_m_ff, clip_m_ff, rpm_m_ff}),
      .out_valid (v2), .quotient (q2), .ovf (ovf2), .out_tag (tag2)
   );

   // clamp to full scale
   logic                     over_in;
   logic [FULL_W-1:0]        qq_in;
   logic signed [DUTY_W-1:0] duty_in, duty_ff;
   logic                     clip_in, clip_o_ff, valid_o_ff;
   logic signed [RPM_W-1:0]  rpm_o_ff;

   always_comb begin
      over_in = ovf2 || (q2 > {1'b0, full});
      qq_in   = over_in ? full : q2[FULL_W-1:0];
      duty_in = tag2[TAG2_W-1] ? -$signed({1'b0, qq_in}) : $signed({1'b0, qq_in});
      clip_in = tag2[RPM_W] || over_in ||
                ((full == '0) && (tag2[RPM_W-1:0] != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else if (en) begin
         valid_o_ff <= v2;
      end
      if (en) begin
         duty_ff   <= duty_in;
         clip_o_ff <= clip_in;
         rpm_o_ff  <= $signed(tag2[RPM_W-1:0]);
      end
   end

   assign out_valid = valid_o_ff;
   assign rpm       = rpm_o_ff;
   assign duty      = duty_ff;
   assign clip      = clip_o_ff;
endmodule
`default_nettype wire

### sv/diff_drive_wheel_command_unit.sv
// top level of the differential drive wheel command unit
// Turns a body command (forward speed in mm/s, yaw rate in mrad/s) into left
// and right wheel rpm and signed pwm duty values. One command is taken every
// cycle unless rsp is stalled. A req transfer reaches its rsp transfer through
// three front stages (scale, sum, magnitude times 60), an 18-stage bit-per-stage
// rpm divider, a saturation stage, a duty multiply stage, an 18-stage duty
// divider and the output register. The whole pipe moves on one enable, so a
// stalled rsp holds every stage and req.ready drops with it. Configuration
// values are folded on write (circumference doubled, zero taken as one, pwm
// full scale precomputed) and must only be changed while the pipe is empty.
`default_nettype none
module diff_drive_wheel_command_unit #(
   parameter int SPEED_WIDTH = ddwc_pkg::SPEED_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ddwc_req_if.sink                               req,
   ddwc_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [ddwc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ddwc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ddwc_pkg::*;

   // config, stored in the form the datapath wants
   logic [CIRC_W:0]     circ2_ff;
   logic [TRACK_W-1:0]  track_ff;
   logic [MAXRPM_W-1:0] maxrpm_ff;
   logic [FULL_W-1:0]   full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         circ2_ff  <= CIRC2_RESET;
         track_ff  <= TRACK_RESET;
         maxrpm_ff <= MAXRPM_RESET;
         full_ff   <= FULL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CIRC: begin
               // zero circumference acts as one micrometre
               circ2_ff <= (csr_wdata == '0) ? (CIRC_W+1)'(2) : {csr_wdata, 1'b0};
            end
            CSR_TRACK: begin
               track_ff <= csr_wdata[TRACK_W-1:0];
            end
            CSR_MAXRPM: begin
               maxrpm_ff <= (csr_wdata[MAXRPM_W-1:0] == '0) ? MAXRPM_W'(1)
                                                            : csr_wdata[MAXRPM_W-1:0];
            end
            CSR_BITS: begin
               full_ff <= full_scale(csr_wdata[BITS_W-1:0]);
            end
            default: begin
               // writes past the last register are dropped
            end
         endcase
      end
   end

   // global advance: any stage moves only when the output slot is free or taken
   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   logic                   f_valid, neg_l, neg_r;
   logic [SPEED_WIDTH+19:0] dvd_l, dvd_r;

   ddwc_front #(.SW(SPEED_WIDTH)) u_front (
      .clock, .reset, .en,
      .in_valid     (req.valid),
      .linear_speed (req.linear_speed),
      .yaw_rate     (req.yaw_rate),
      .track        (track_ff),
      .out_valid    (f_valid),
      .dvd_l        (dvd_l),
      .dvd_r        (dvd_r),
      .neg_l        (neg_l),
      .neg_r        (neg_r)
   );

   logic l_valid, r_valid, l_clip, r_clip;

   ddwc_wheel #(.SW(SPEED_WIDTH)) u_left (
      .clock, .reset, .en,
      .in_valid (f_valid), .dvd (dvd_l), .neg (neg_l),
      .circ2 (circ2_ff), .maxrpm (maxrpm_ff), .full (full_ff),
      .out_valid (l_valid), .rpm (rsp.left_rpm), .duty (rsp.left_duty), .clip (l_clip)
   );

   ddwc_wheel #(.SW(SPEED_WIDTH)) u_right (
      .clock, .reset, .en,
      .in_valid (f_valid), .dvd (dvd_r), .neg (neg_r),
      .circ2 (circ2_ff), .maxrpm (maxrpm_ff), .full (full_ff),
      .out_valid (r_valid), .rpm (rsp.right_rpm), .duty (rsp.right_duty), .clip (r_clip)
   );

   // both wheels run in lockstep, so their valids always agree
   assign rsp.valid   = l_valid && r_valid;
   assign rsp.clipped = l_clip || r_clip;
endmodule
`default_nettype wire

### sv/ddwc_checker.sv
// port-level checks of the wheel command unit, bound to the top level
`default_nettype none
module ddwc_checker (
   input wire logic   clock,
   input wire logic   reset,
   ddwc_req_if.sink   req,
   ddwc_rsp_if.source rsp
);
   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp valid right after reset");

   // a stalled result holds its payload (left rpm, right duty and clip flag checked)
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.left_rpm) &&
      $stable(rsp.right_duty) && $stable(rsp.clipped))
      else $error("stalled rsp changed");

   // a stalled output freezes the whole pipe, intake included
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("req taken while rsp stalled");

   // duty sign never opposes rpm: left at positive rpm, right at negative rpm
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !((rsp.left_rpm > 0) && (rsp.left_duty < 0)) &&
                    !((rsp.right_rpm < 0) && (rsp.right_duty > 0)))
      else $error("duty sign disagrees with rpm");

   // zero left rpm gives zero left duty
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.left_rpm == 0) |-> (rsp.left_duty == 0))
      else $error("nonzero duty at zero rpm");
endmodule

bind diff_drive_wheel_command_unit ddwc_checker u_ddwc_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
`default_nettype wire

### dv/ddwc_tb_if.sv
// testbench item types of the wheel command unit
`timescale 1ns / 100ps
package ddwc_tb_pkg;
   typedef struct packed {
      logic signed [15:0] linear_speed;
      logic signed [15:0] yaw_rate;
   } wheel_cmd_type;

   typedef struct packed {
      logic signed [15:0] left_rpm;
      logic signed [15:0] right_rpm;
      logic signed [16:0] left_duty;
      logic signed [16:0] right_duty;
      logic               clipped;
   } wheel_out_type;
endpackage

### dv/diff_drive_wheel_command_unit_tb.sv
// self-checking testbench of the wheel command unit with random traffic and config sweeps
`timescale 1ns / 100ps
module diff_drive_wheel_command_unit_tb;
   import ddwc_pkg::*;
   import ddwc_tb_pkg::*;

   localparam int PIPE_LAT = 42;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ddwc_req_if #(.SPEED_WIDTH(16)) req ();
   ddwc_rsp_if rsp ();

   diff_drive_wheel_command_unit #(.SPEED_WIDTH(16)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow copy of the configuration registers
   logic [19:0] circ_um = 20'd314159;
   logic [11:0] track_mm = 12'd300;
   logic [13:0] max_rpm = 14'd140;
   logic [4:0]  pwm_res = 5'd8;

   wheel_cmd_type cmd_queue[$];
   wheel_out_type wheel_expect[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit send_hold = 1'b0;
   // set at each rising edge that carried a req transfer
   bit req_taken = 1'b0;

   // rpm from the signed surface speed numerator, saturating
   function automatic logic signed [15:0] calc_rpm(input longint num, input longint circ,
                                                   inout bit clip);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag * 60) / (2 * circ);
      if (num < 0) begin
         if (q > 32768) begin clip = 1; return -16'sd32768; end
         return 16'(-q);
      end
      if (q > 32767) begin clip = 1; return 16'sd32767; end
      return 16'(q);
   endfunction

   function automatic logic signed [16:0] calc_duty(input logic signed [15:0] rpm,
                                                    input longint maxr, input longint full,
                                                    inout bit clip);
      longint mag, q;
      mag = (rpm < 0) ? -longint'(rpm) : longint'(rpm);
      q = (mag * full) / maxr;
      if (q > full) begin q = full; clip = 1; end
      if (full == 0 && mag != 0) clip = 1;
      return 17'((rpm < 0) ? -q : q);
   endfunction

   function automatic wheel_out_type predict_wheels(input wheel_cmd_type c);
      wheel_out_type o;
      bit clip;
      longint circ, maxr, full, lin, tang;
      int b;
      clip = 0;
      circ = (circ_um == 0) ? 1 : circ_um;
      maxr = (max_rpm == 0) ? 1 : max_rpm;
      b = (pwm_res > 16) ? 16 : pwm_res;
      full = (longint'(1) << b) - 1;
      lin = longint'(c.linear_speed) * 2000;
      tang = longint'(c.yaw_rate) * longint'(track_mm);
      o.left_rpm = calc_rpm(lin - tang, circ, clip);
      o.right_rpm = calc_rpm(lin + tang, circ, clip);
      o.left_duty = calc_duty(o.left_rpm, maxr, full, clip);
      o.right_duty = calc_duty(o.right_rpm, maxr, full, clip);
      o.clipped = clip;
      return o;
   endfunction

   // driver: valid only drops after a transfer or while idling
   initial begin
      req.valid = 1'b0;
      req.linear_speed = '0;
      req.yaw_rate = '0;
      rsp.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req.valid || req_taken) begin
            if (cmd_queue.size() > 0 && !send_hold &&
                $urandom_range(99, 0) >= send_idle_pct) begin
               req.valid <= 1'b1;
               req.linear_speed <= cmd_queue[0].linear_speed;
               req.yaw_rate <= cmd_queue[0].yaw_rate;
            end else begin
               req.valid <= 1'b0;
            end
         end
         rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // predict at the req transfer, pop the driver queue
   always @(posedge clock) begin
      req_taken = !reset && req.valid && req.ready;
      if (req_taken) begin
         wheel_expect.push_back(predict_wheels(cmd_queue[0]));
         cmd_queue.pop_front();
      end
   end

   // monitor: compare each rsp transfer with the oldest expectation
   always @(posedge clock) begin
      wheel_out_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.left_rpm, rsp.right_rpm, rsp.left_duty, rsp.right_duty, rsp.clipped};
         if (wheel_expect.size() == 0) begin
            $display("%0t unexpected rsp transfer: expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = wheel_expect.pop_front();
            if (got.left_rpm !== want.left_rpm) begin
               $display("%0t left_rpm mismatch: expected %0d, actual %0d",
                        $time, want.left_rpm, got.left_rpm);
               fail_count++;
            end
            if (got.right_rpm !== want.right_rpm) begin
               $display("%0t right_rpm mismatch: expected %0d, actual %0d",
                        $time, want.right_rpm, got.right_rpm);
               fail_count++;
            end
            if (got.left_duty !== want.left_duty) begin
               $display("%0t left_duty mismatch: expected %0d, actual %0d",
                        $time, want.left_duty, got.left_duty);
               fail_count++;
            end
            if (got.right_duty !== want.right_duty) begin
               $display("%0t right_duty mismatch: expected %0d, actual %0d",
                        $time, want.right_duty, got.right_duty);
               fail_count++;
            end
            if (got.clipped !== want.clipped) begin
               $display("%0t clipped mismatch: expected %0d, actual %0d",
                        $time, want.clipped, got.clipped);
               fail_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (cmd_queue.size() > 0 || wheel_expect.size() > 0 || req.valid)
         @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // register write at the falling edge, lands at the next rising edge
   task automatic csr_write(input csr_index_type idx, input logic [19:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CIRC:   circ_um = val[19:0];
         CSR_TRACK:  track_mm = val[11:0];
         CSR_MAXRPM: max_rpm = val[13:0];
         CSR_BITS:   pwm_res = val[4:0];
         default: ;
      endcase
   endtask

   task automatic push_cmd(input logic [15:0] v, input logic [15:0] w);
      wheel_cmd_type c;
      c.linear_speed = v;
      c.yaw_rate = w;
      cmd_queue.push_back(c);
   endtask

   // mostly modest speeds so rpm stays in range, sometimes full-range
   task automatic push_random(input int n);
      repeat (n) begin
         if ($urandom_range(3, 0) == 0)
            push_cmd(16'($urandom), 16'($urandom));
         else
            push_cmd(16'($urandom_range(4000, 0) - 2000),
                     16'($urandom_range(8000, 0) - 4000));
      end
   endtask

   task automatic random_config();
      csr_write(CSR_CIRC, 20'(($urandom_range(1, 0)) ? $urandom_range(400000, 50000)
                                                     : $urandom_range(1048575, 0)));
      csr_write(CSR_TRACK, 20'($urandom_range(4095, 0)));
      csr_write(CSR_MAXRPM, 20'(($urandom_range(1, 0)) ? $urandom_range(500, 1)
                                                       : $urandom_range(16383, 0)));
      csr_write(CSR_BITS, 20'($urandom_range(31, 0)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, zero, turning in place, default config
      push_cmd(16'sd0, 16'sd0);
      push_cmd(16'sd32767, 16'sd0);
      push_cmd(-16'sd32768, 16'sd0);
      push_cmd(16'sd0, 16'sd32767);
      push_cmd(16'sd0, -16'sd32768);
      push_cmd(16'sd32767, 16'sd32767);
      push_cmd(-16'sd32768, -16'sd32768);
      push_cmd(16'sd500, 16'sd1000);
      push_cmd(-16'sd500, 16'sd1000);
      push_cmd(16'sd1, -16'sd1);
      wait_drained();

      // zero circumference, zero track, zero max rpm, zero pwm bits
      csr_write(CSR_CIRC, 20'd0);
      csr_write(CSR_MAXRPM, 20'd0);
      csr_write(CSR_BITS, 20'd0);
      csr_write(CSR_TRACK, 20'd0);
      push_cmd(16'sd0, 16'sd0);
      push_cmd(16'sd1, 16'sd5);
      push_cmd(-16'sd32768, 16'sd32767);
      wait_drained();

      // max registers, pwm bits over sixteen
      csr_write(CSR_CIRC, 20'hFFFFF);
      csr_write(CSR_TRACK, 20'hFFF);
      csr_write(CSR_MAXRPM, 20'h3FFF);
      csr_write(CSR_BITS, 20'd31);
      push_cmd(16'sd32767, -16'sd32768);
      push_cmd(-16'sd32768, 16'sd32767);
      push_cmd(16'sd100, 16'sd100);
      wait_drained();

      // sixteen bits full scale, tiny max rpm
      csr_write(CSR_CIRC, 20'd1000);
      csr_write(CSR_MAXRPM, 20'd1);
      csr_write(CSR_BITS, 20'd16);
      push_cmd(16'sd3, 16'sd0);
      push_cmd(-16'sd3, 16'sd0);
      push_cmd(16'sd0, 16'sd0);
      wait_drained();

      // random phases with the idling profiles
      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin send_idle_pct = 31; recv_idle_pct = 63; end
         else if (ph < 6) begin send_idle_pct = 63; recv_idle_pct = 31; end
         else begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (ph == 0) begin
            csr_write(CSR_CIRC, 20'd314159);
            csr_write(CSR_TRACK, 20'd300);
            csr_write(CSR_MAXRPM, 20'd140);
            csr_write(CSR_BITS, 20'd8);
         end else begin
            random_config();
         end
         push_random(33);
         // sender pauses until the pipe drains, then resumes
         if (ph == 4) begin
            while (cmd_queue.size() > 0) @(posedge clock);
            @(negedge clock);
            send_hold = 1'b1;
            while (wheel_expect.size() > 0 || req.valid) @(posedge clock);
            @(negedge clock);
            send_hold = 1'b0;
         end
         push_random(34);
         wait_drained();
      end

      if (fail_count == 0)
         $display("diff_drive_wheel_command_unit verification clean");
      else
         $display("diff_drive_wheel_command_unit verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("diff_drive_wheel_command_unit verification failed");
      $finish;
   end
endmodule
